// ----- hw/rtl/ttc_pkg.sv -----
`default_nettype none

package ttc_pkg;

  // register file layout
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HOME_X   = 3'd0,
    REG_HOME_Y   = 3'd1,
    REG_LEFT     = 3'd2,
    REG_STEP_X   = 3'd3,
    REG_STEP_Y   = 3'd4,
    REG_GLYPH_W  = 3'd5,
    REG_SCREEN_W = 3'd6,
    REG_SCREEN_H = 3'd7
  } reg_idx_t;

  // reset values, truncated to the coordinate width where used
  localparam int RST_HOME_X   = 8;
  localparam int RST_HOME_Y   = 8;
  localparam int RST_LEFT     = 8;
  localparam int RST_STEP_X   = 8;
  localparam int RST_STEP_Y   = 10;
  localparam int RST_GLYPH_W  = 8;
  localparam int RST_SCREEN_W = 512;
  localparam int RST_SCREEN_H = 384;

  // character codes
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_CR       = 8'h0D;

  localparam int GLYPH_BITS = 7;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_SCROLL = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ttc_regs.sv -----
`default_nettype none

module ttc_regs
  import ttc_pkg::*;
#(
  parameter int CB = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CB-1:0]           cfg_data,
  output logic [CB-1:0]                home_x,
  output logic [CB-1:0]                home_y,
  output logic [CB-1:0]                left_margin,
  output logic [CB-1:0]                step_x,
  output logic [CB-1:0]                step_y,
  output logic [CB-1:0]                glyph_width,
  output logic [CB-1:0]                screen_width,
  output logic [CB-1:0]                screen_height
);

  logic [CB-1:0] home_x_r, home_y_r, left_r, step_x_r, step_y_r;
  logic [CB-1:0] glyph_w_r, screen_w_r, screen_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r   <= CB'(RST_HOME_X);
      home_y_r   <= CB'(RST_HOME_Y);
      left_r     <= CB'(RST_LEFT);
      step_x_r   <= CB'(RST_STEP_X);
      step_y_r   <= CB'(RST_STEP_Y);
      glyph_w_r  <= CB'(RST_GLYPH_W);
      screen_w_r <= CB'(RST_SCREEN_W);
      screen_h_r <= CB'(RST_SCREEN_H);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_HOME_X:   home_x_r   <= cfg_data;
        REG_HOME_Y:   home_y_r   <= cfg_data;
        REG_LEFT:     left_r     <= cfg_data;
        REG_STEP_X:   step_x_r   <= cfg_data;
        REG_STEP_Y:   step_y_r   <= cfg_data;
        REG_GLYPH_W:  glyph_w_r  <= cfg_data;
        REG_SCREEN_W: screen_w_r <= cfg_data;
        REG_SCREEN_H: screen_h_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign home_x        = home_x_r;
  assign home_y        = home_y_r;
  assign left_margin   = left_r;
  assign step_x        = step_x_r;
  assign step_y        = step_y_r;
  assign glyph_width   = glyph_w_r;
  assign screen_width  = screen_w_r;
  assign screen_height = screen_h_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ttc_step.sv -----
`default_nettype none

module ttc_step
  import ttc_pkg::*;
#(
  parameter int CB = 12
) (
  input  wire logic [7:0]       char_code,
  input  wire logic [CB-1:0]    cur_x,
  input  wire logic [CB-1:0]    cur_y,
  input  wire logic [CB-1:0]    left_margin,
  input  wire logic [CB-1:0]    step_x,
  input  wire logic [CB-1:0]    step_y,
  input  wire logic [CB-1:0]    glyph_width,
  input  wire logic [CB-1:0]    screen_width,
  input  wire logic [CB-1:0]    screen_height,
  output logic [GLYPH_BITS-1:0] glyph,
  output logic                  scroll,
  output logic [CB-1:0]         next_x,
  output logic [CB-1:0]         next_y
);

  localparam int WB = CB + 2;
  localparam logic [CB-1:0] COORD_MAX = {CB{1'b1}};

  logic          printable, is_bs, is_cr, wrap, new_line, scroll_chk;
  logic [WB-1:0] x_adv, x_edge, y_line, y_edge;
  logic [7:0]    glyph_full;

  always_comb begin
    printable  = (char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI);
    is_bs      = (char_code == CH_BS) || (char_code == CH_DEL);
    is_cr      = (char_code == CH_CR);
    glyph_full = char_code - CH_PRINT_LO;
    glyph      = printable ? glyph_full[GLYPH_BITS-1:0] : '0;

    // exact sums, two spare bits
    x_adv  = WB'(cur_x) + WB'(step_x);
    x_edge = x_adv + WB'(glyph_width);
    wrap   = x_edge >= WB'(screen_width);
    y_line = WB'(cur_y) + WB'(step_y);
    y_edge = y_line + WB'(step_y);
    scroll_chk = y_edge >= WB'(screen_height);

    new_line = (printable && wrap) || is_cr;
    scroll   = 1'b0;
    next_x   = cur_x;
    next_y   = cur_y;

    if (new_line) begin
      next_x = left_margin;
      if (scroll_chk) begin
        scroll = 1'b1;
      end else begin
        next_y = (y_line > WB'(COORD_MAX)) ? COORD_MAX : y_line[CB-1:0];
      end
    end else if (printable) begin
      next_x = (x_adv > WB'(COORD_MAX)) ? COORD_MAX : x_adv[CB-1:0];
    end else if (is_bs) begin
      if ((cur_x < step_x) || ((cur_x - step_x) < left_margin)) begin
        next_x = left_margin;
      end else begin
        next_x = cur_x - step_x;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/text_terminal_cursor_control.sv -----
// a character passes through the input register and then the output register before its draw word is offered
// throughput: one character per cycle while out_ready stays high; after a scroll the next waits for the scroll word
// the input register takes one more character while a finished word waits
// reset (synchronous, active low): registers to defaults, cursor to (8, 8),
// both stages empty
`default_nettype none

module text_terminal_cursor_control
  import ttc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // character input
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_char_code,
  // command output
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_command,
  output logic [GLYPH_BITS-1:0]        out_glyph_index,
  output logic [COORD_BITS-1:0]        out_draw_x,
  output logic [COORD_BITS-1:0]        out_draw_y,
  output logic [COORD_BITS-1:0]        out_scroll_rows,
  output logic [COORD_BITS-1:0]        out_cursor_x_after,
  output logic [COORD_BITS-1:0]        out_cursor_y_after,
  output logic                         out_last,
  // register writes
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0]   cfg_data
);

  localparam int CB = COORD_BITS;

  // register file
  logic [CB-1:0] home_x, home_y, left_margin, step_x, step_y;
  logic [CB-1:0] glyph_width, screen_width, screen_height;

  ttc_regs #(.CB(CB)) u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .home_x        (home_x),
    .home_y        (home_y),
    .left_margin   (left_margin),
    .step_x        (step_x),
    .step_y        (step_y),
    .glyph_width   (glyph_width),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;

  // cursor
  logic [CB-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;

  // output register plus a pending scroll word
  logic                  out_valid_r, out_valid_nxt;
  logic                  pend_r, pend_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [GLYPH_BITS-1:0] glyph_r, glyph_nxt;
  logic [CB-1:0]         dx_r, dx_nxt, dy_r, dy_nxt, rows_r, rows_nxt;
  logic [CB-1:0]         cx_r, cx_nxt, cy_r, cy_nxt, pend_rows_r, pend_rows_nxt;
  logic                  last_r, last_nxt;

  // cursor arithmetic for the character in the input register
  logic [GLYPH_BITS-1:0] st_glyph;
  logic                  st_scroll;
  logic [CB-1:0]         st_x, st_y;

  ttc_step #(.CB(CB)) u_step (
    .char_code     (s1_char_r),
    .cur_x         (cur_x_r),
    .cur_y         (cur_y_r),
    .left_margin   (left_margin),
    .step_x        (step_x),
    .step_y        (step_y),
    .glyph_width   (glyph_width),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .glyph         (st_glyph),
    .scroll        (st_scroll),
    .next_x        (st_x),
    .next_y        (st_y)
  );

  logic out_take, load_out, in_take, home_wr;

  always_comb begin
    out_take = out_valid_r && out_ready;
    // the output register is free when empty, or once its word leaves with no scroll word behind it
    load_out = s1_valid_r && (!out_valid_r || (out_take && !pend_r));
    in_ready = !s1_valid_r || load_out;
    in_take  = in_valid && in_ready;
    home_wr  = cfg_we && ((reg_idx_t'(cfg_index) == REG_HOME_X) ||
                          (reg_idx_t'(cfg_index) == REG_HOME_Y));

    s1_valid_nxt = in_take || (s1_valid_r && !load_out);

    // a home write lands on the cursor together with the new register value
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (home_wr) begin
      cur_x_nxt = (reg_idx_t'(cfg_index) == REG_HOME_X) ? cfg_data : home_x;
      cur_y_nxt = (reg_idx_t'(cfg_index) == REG_HOME_Y) ? cfg_data : home_y;
    end else if (load_out) begin
      cur_x_nxt = st_x;
      cur_y_nxt = st_y;
    end

    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    pend_rows_nxt = pend_rows_r;
    cmd_nxt       = cmd_r;
    glyph_nxt     = glyph_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    rows_nxt      = rows_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    last_nxt      = last_r;

    if (load_out) begin
      // draw word, scroll word held back if the line ran off the bottom
      out_valid_nxt = 1'b1;
      pend_nxt      = st_scroll;
      pend_rows_nxt = step_y;
      cmd_nxt       = CMD_DRAW;
      glyph_nxt     = st_glyph;
      dx_nxt        = cur_x_r;
      dy_nxt        = cur_y_r;
      rows_nxt      = '0;
      cx_nxt        = st_x;
      cy_nxt        = st_y;
      last_nxt      = !st_scroll;
    end else if (out_take && pend_r) begin
      // scroll word follows the draw word, same cursor
      pend_nxt  = 1'b0;
      cmd_nxt   = CMD_SCROLL;
      glyph_nxt = '0;
      dx_nxt    = '0;
      dy_nxt    = '0;
      rows_nxt  = pend_rows_r;
      last_nxt  = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cur_x_r     <= CB'(RST_HOME_X);
      cur_y_r     <= CB'(RST_HOME_Y);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
    end
    pend_rows_r <= pend_rows_nxt;
    cmd_r       <= cmd_nxt;
    glyph_r     <= glyph_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    rows_r      <= rows_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    last_r      <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_command        = cmd_r;
  assign out_glyph_index    = glyph_r;
  assign out_draw_x         = dx_r;
  assign out_draw_y         = dy_r;
  assign out_scroll_rows    = rows_r;
  assign out_cursor_x_after = cx_r;
  assign out_cursor_y_after = cy_r;
  assign out_last           = last_r;

`ifndef ASSERT_OFF
  // a pending scroll word only exists behind a word on show
  a_pend_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("scroll word pending with empty output register");

  // taking a draw word with a scroll behind it brings the scroll word next
  a_scroll_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && pend_r) |=> (out_valid_r && cmd_r == CMD_SCROLL && last_r))
    else $error("scroll word did not follow its draw word");

  // only the draw word with a scroll behind it is not the last
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == !pend_r))
    else $error("last flag disagrees with pending scroll");

  // a scroll word carries no glyph or position
  a_scroll_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cmd_r == CMD_SCROLL) |-> (glyph_r == '0 && dx_r == '0 && dy_r == '0))
    else $error("scroll word with glyph fields set");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int CW = 12;
  localparam int NREG = 8;
  // a phase should never need this many cycles to drain
  localparam int unsigned DRAIN_LIMIT = 20000;

  typedef logic [CW-1:0] coord_t;
  localparam coord_t COORD_TOP = '1;

  // one command word as the terminal should emit it
  typedef struct {
    cmd_t                  command;
    logic [GLYPH_BITS-1:0] glyph;
    coord_t                draw_x;
    coord_t                draw_y;
    coord_t                rows;
    coord_t                cur_x;
    coord_t                cur_y;
    logic                  last;
  } term_cmd_t;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // character channel
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = '0;

  // command channel
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_command;
  logic [GLYPH_BITS-1:0] out_glyph_index;
  coord_t                out_draw_x;
  coord_t                out_draw_y;
  coord_t                out_scroll_rows;
  coord_t                out_cursor_x_after;
  coord_t                out_cursor_y_after;
  logic                  out_last;

  // register write port
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  coord_t                  cfg_data = '0;

  text_terminal_cursor_control #(
    .COORD_BITS(CW)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_glyph_index   (out_glyph_index),
    .out_draw_x        (out_draw_x),
    .out_draw_y        (out_draw_y),
    .out_scroll_rows   (out_scroll_rows),
    .out_cursor_x_after(out_cursor_x_after),
    .out_cursor_y_after(out_cursor_y_after),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // characters waiting to be offered, and command words still owed by the block
  logic [7:0] char_q [$];
  term_cmd_t  cmd_expect_q [$];
  int unsigned mismatches = 0;

  // idling switches, changed only between phases
  bit in_idle = 1'b0;
  bit out_idle = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;

  // shadow of the register file and of the cursor
  coord_t shadow_reg [NREG];
  coord_t pos_x;
  coord_t pos_y;

  function automatic coord_t clip(input int unsigned v);
    return (v > COORD_TOP) ? COORD_TOP : coord_t'(v);
  endfunction

  function automatic int unsigned pause(input bit on);
    return on ? $urandom_range(0, 14) : 0;
  endfunction

  // new text line; returns 1 when the bottom is reached and the bitmap must scroll
  function automatic bit new_row();
    int unsigned ny;
    ny = pos_y + shadow_reg[REG_STEP_Y];
    pos_x = shadow_reg[REG_LEFT];
    if (ny + shadow_reg[REG_STEP_Y] >= shadow_reg[REG_SCREEN_H]) return 1'b1;
    pos_y = clip(ny);
    return 1'b0;
  endfunction

  // works out the command words for one accepted character and moves the cursor
  task automatic track_char(input logic [7:0] code);
    term_cmd_t   draw_w;
    term_cmd_t   scroll_w;
    int unsigned nx;
    bit          printable;
    bit          scroll;
    printable = (code >= CH_PRINT_LO) && (code <= CH_PRINT_HI);
    scroll = 1'b0;
    draw_w.command = CMD_DRAW;
    draw_w.glyph = printable ? GLYPH_BITS'(code - CH_PRINT_LO) : '0;
    draw_w.draw_x = pos_x;
    draw_w.draw_y = pos_y;
    draw_w.rows = '0;
    if (printable) begin
      // wrap when the next glyph would reach the right edge
      nx = pos_x + shadow_reg[REG_STEP_X];
      if (nx + shadow_reg[REG_GLYPH_W] >= shadow_reg[REG_SCREEN_W]) begin
        scroll = new_row();
      end else begin
        pos_x = clip(nx);
      end
    end else if (code == CH_BS || code == CH_DEL) begin
      // step back, never past the left margin
      if (pos_x < shadow_reg[REG_STEP_X] ||
          pos_x - shadow_reg[REG_STEP_X] < shadow_reg[REG_LEFT]) begin
        pos_x = shadow_reg[REG_LEFT];
      end else begin
        pos_x = pos_x - shadow_reg[REG_STEP_X];
      end
    end else if (code == CH_CR) begin
      scroll = new_row();
    end
    // every other code draws the blank glyph and leaves the cursor alone
    draw_w.cur_x = pos_x;
    draw_w.cur_y = pos_y;
    draw_w.last = !scroll;
    cmd_expect_q.push_back(draw_w);
    if (scroll) begin
      // scroll word carries the same final cursor, no glyph or position
      scroll_w = draw_w;
      scroll_w.command = CMD_SCROLL;
      scroll_w.glyph = '0;
      scroll_w.draw_x = '0;
      scroll_w.draw_y = '0;
      scroll_w.rows = shadow_reg[REG_STEP_Y];
      scroll_w.last = 1'b1;
      cmd_expect_q.push_back(scroll_w);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // one command word taken from the block, checked against the oldest one owed
  task automatic check_word();
    term_cmd_t want;
    if (cmd_expect_q.size() == 0) begin
      $error("unexpected command word: command %0d glyph_index %0d",
             out_command, out_glyph_index);
      mismatches++;
    end else begin
      want = cmd_expect_q.pop_front();
      compare_field("command", want.command, out_command);
      compare_field("glyph_index", want.glyph, out_glyph_index);
      compare_field("draw_x", want.draw_x, out_draw_x);
      compare_field("draw_y", want.draw_y, out_draw_y);
      compare_field("scroll_rows", want.rows, out_scroll_rows);
      compare_field("cursor_x_after", want.cur_x, out_cursor_x_after);
      compare_field("cursor_y_after", want.cur_y, out_cursor_y_after);
      compare_field("last", want.last, out_last);
    end
  endtask

  // character driver: a new word is loaded in the same step as the last one is
  // taken, so valid is only ever assigned once per edge
  always @(posedge clk) begin : feed
    logic hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready) begin
        track_char(in_char_code);
        hold = 1'b0;
        in_wait = pause(in_idle);
      end
      if (!hold) begin
        if (in_wait != 0) begin
          in_wait--;
        end else if (char_q.size() != 0) begin
          in_char_code <= char_q.pop_front();
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  // command monitor: ready may drop for a random stall after each word taken, when output idling is on
  always @(posedge clk) begin : watch
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      rdy = out_ready;
      if (out_valid && out_ready) begin
        check_word();
        out_wait = pause(out_idle);
        if (out_wait != 0) rdy = 1'b0;
      end else if (!out_ready) begin
        if (out_wait != 0) out_wait--;
        if (out_wait == 0) rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  // register write; a home write also sends the shadow cursor home
  task automatic cfg_write(input reg_idx_t idx, input coord_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reg[idx] = val;
    if (idx == REG_HOME_X || idx == REG_HOME_Y) begin
      pos_x = shadow_reg[REG_HOME_X];
      pos_y = shadow_reg[REG_HOME_Y];
    end
  endtask

  // sampled on the falling edge so the queues are stable
  task automatic settle();
    int unsigned spins;
    spins = 0;
    while ((char_q.size() != 0 || in_valid || cmd_expect_q.size() != 0) &&
           spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (spins >= DRAIN_LIMIT) begin
      $error("phase stuck: %0d characters and %0d command words outstanding",
             char_q.size(), cmd_expect_q.size());
      mismatches++;
    end
  endtask

  task automatic set_idling();
    case ($urandom_range(0, 3))
      0: begin in_idle = 1'b0; out_idle = 1'b0; end
      1: begin in_idle = 1'b1; out_idle = 1'b0; end
      2: begin in_idle = 1'b0; out_idle = 1'b1; end
      default: begin in_idle = 1'b1; out_idle = 1'b1; end
    endcase
  endtask

  // mostly a small terminal so that wraps and scrolls come often, now and
  // then zero, one or the top value of the register
  function automatic coord_t pick_reg(input reg_idx_t idx);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return coord_t'(1);
      default: begin
        case (idx)
          REG_HOME_X, REG_LEFT:  return coord_t'($urandom_range(0, 64));
          REG_HOME_Y:            return coord_t'($urandom_range(0, 48));
          REG_STEP_X, REG_STEP_Y: return coord_t'($urandom_range(1, 16));
          REG_GLYPH_W:           return coord_t'($urandom_range(0, 16));
          REG_SCREEN_W:          return coord_t'($urandom_range(16, 320));
          default:               return coord_t'($urandom_range(16, 240));
        endcase
      end
    endcase
  endfunction

  // weighted towards text, with plenty of returns and backspaces
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    if (r < 67) return CH_CR;
    if (r < 73) return CH_BS;
    if (r < 79) return CH_DEL;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    // default registers from (8, 8): each code class, then the backspace clamp
    logic [7:0] opening [12] = '{8'h41, 8'h20, 8'h7E, 8'h00, 8'hFF, 8'h80,
                                 8'h1F, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h0D};
    // tiny screen: wrap, carriage return, scroll at the bottom, clamp again
    logic [7:0] tiny [12] = '{8'h61, 8'h30, 8'h7A, 8'h21, 8'h0D, 8'h0D,
                              8'h0D, 8'h7E, 8'h7F, 8'h08, 8'h08, 8'h0D};
    reg_idx_t   idx;
    int unsigned n;

    shadow_reg[REG_HOME_X]   = coord_t'(RST_HOME_X);
    shadow_reg[REG_HOME_Y]   = coord_t'(RST_HOME_Y);
    shadow_reg[REG_LEFT]     = coord_t'(RST_LEFT);
    shadow_reg[REG_STEP_X]   = coord_t'(RST_STEP_X);
    shadow_reg[REG_STEP_Y]   = coord_t'(RST_STEP_Y);
    shadow_reg[REG_GLYPH_W]  = coord_t'(RST_GLYPH_W);
    shadow_reg[REG_SCREEN_W] = coord_t'(RST_SCREEN_W);
    shadow_reg[REG_SCREEN_H] = coord_t'(RST_SCREEN_H);
    pos_x = shadow_reg[REG_HOME_X];
    pos_y = shadow_reg[REG_HOME_Y];

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) char_q.push_back(opening[i]);
    settle();

    cfg_write(REG_HOME_X, coord_t'(4));
    cfg_write(REG_HOME_Y, coord_t'(0));
    cfg_write(REG_LEFT, coord_t'(2));
    cfg_write(REG_STEP_X, coord_t'(8));
    cfg_write(REG_STEP_Y, coord_t'(10));
    cfg_write(REG_GLYPH_W, coord_t'(8));
    cfg_write(REG_SCREEN_W, coord_t'(40));
    cfg_write(REG_SCREEN_H, coord_t'(35));
    in_idle = 1'b1;
    out_idle = 1'b1;
    foreach (tiny[i]) char_q.push_back(tiny[i]);
    settle();
    // home write alone moves the cursor, next glyph then wraps
    cfg_write(REG_HOME_X, coord_t'(30));
    char_q.push_back(8'h51);
    settle();

    // both extremes of every register, then random settings
    for (int p = 0; p < 12; p++) begin
      for (int r = 0; r < NREG; r++) begin
        idx = reg_idx_t'(r);
        if (p == 0) cfg_write(idx, '0);
        else if (p == 1) cfg_write(idx, '1);
        else if ($urandom_range(0, 1) == 1) cfg_write(idx, pick_reg(idx));
      end
      set_idling();
      n = (p < 2) ? 40 : $urandom_range(90, 120);
      repeat (n) char_q.push_back(pick_char());
      settle();
    end

    repeat (10) @(posedge clk);
    if (cmd_expect_q.size() != 0) begin
      $error("%0d command words never arrived", cmd_expect_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
